FILE: design/ghp_pkg.sv
// ----------------------------------------------------------------------------
// ghp_pkg
// Shared codes and control structs for the generational handle pool.
// ----------------------------------------------------------------------------
`default_nettype none

package ghp_pkg;

  localparam logic       KIND_ALLOC   = 1'b0;
  localparam logic       KIND_FREE    = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_BAD_SLOT  = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

  typedef struct packed {
    logic ready;
    logic empty;
    logic full;
  } stk_stat_t;

endpackage

`default_nettype wire

FILE: design/ghp_stack.sv
// ----------------------------------------------------------------------------
// ghp_stack
// Free slot stack: one synchronous memory plus the top counter. After reset
// a sweep loads entry i with SLOTS minus i, one entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ghp_stack #(
  parameter int SLOTS = 1023
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ghp_pkg::stk_ctrl_t            ctrl,
  input  wire logic [$clog2(SLOTS+1)-1:0]    push_slot,
  output logic      [$clog2(SLOTS+1)-1:0]    pop_slot,
  output ghp_pkg::stk_stat_t                 stat
);
  import ghp_pkg::*;

  localparam int SW = $clog2(SLOTS + 1);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [SW-1:0] mem [0:SLOTS-1];
  logic [SW-1:0] top_r, top_nxt;
  logic [SW-1:0] top_m1;
  logic [SW-1:0] init_cnt_r, init_cnt_nxt;
  logic          init_r, init_nxt;
  logic [SW-1:0] rd_r;

  assign top_m1 = top_r - SW'(1);

  always_comb begin
    top_nxt      = top_r;
    init_nxt     = init_r;
    init_cnt_nxt = init_cnt_r;
    if (init_r) begin
      init_cnt_nxt = init_cnt_r + SW'(1);
      if (init_cnt_r == SW'(SLOTS - 1)) begin
        init_nxt = 1'b0;
      end
    end else if (ctrl.push) begin
      top_nxt = top_r + SW'(1);
    end else if (ctrl.pop) begin
      top_nxt = top_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r      <= SW'(SLOTS);
      init_r     <= 1'b1;
      init_cnt_r <= '0;
    end else begin
      top_r      <= top_nxt;
      init_r     <= init_nxt;
      init_cnt_r <= init_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (init_r) begin
      mem[init_cnt_r[IW-1:0]] <= SW'(SLOTS) - init_cnt_r;
    end else if (ctrl.push) begin
      mem[top_r[IW-1:0]] <= push_slot;
    end
    if (ctrl.pop) begin
      rd_r <= mem[top_m1[IW-1:0]];
    end
  end

  assign pop_slot   = rd_r;
  assign stat.ready = !init_r;
  assign stat.empty = (top_r == '0);
  assign stat.full  = (top_r >= SW'(SLOTS));

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.push |-> !stat.full && stat.ready)
    else $error("push onto full or uninitialized stack");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop |-> !stat.empty && stat.ready)
    else $error("pop from empty or uninitialized stack");

  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= SW'(SLOTS))
    else $error("stack top out of range");

endmodule

`default_nettype wire

FILE: design/generational_handle_pool_top.sv
// ----------------------------------------------------------------------------
// generational_handle_pool_top
// Hands out slot handles from a free stack and takes them back.
// ----------------------------------------------------------------------------
// Input channel in_*: one word per request, kind 0 allocates a handle, kind 1
// frees in_handle (slot index in the low SLOT_BITS bits). Output channel
// out_*: exactly one word per request, new_handle and status.
// A free or an exhausted allocate is answered in the cycle after
// acceptance. A successful allocate goes through stack memory read,
// generation memory read, then generation write-back with the result.
// Throughput: one request at a time; a free every cycle while the output
// is not stalled; an allocate blocks requests through its chained reads.
// Reset: the stack memory (SLOTS entries) and generation memory (SLOTS+1
// entries) are initialized by sweeps; in_stall stays high until both finish.
// A stalled result is held in the output register; one new request can be
// taken in the cycle the held word leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_pool_top #(
  parameter int SLOTS     = 1023,
  parameter int SLOT_BITS = 16,
  parameter int GEN_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_kind,
  input  wire logic [31:0] in_handle,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_new_handle,
  output logic [1:0]       out_status
);
  import ghp_pkg::*;

  localparam int          SW        = $clog2(SLOTS + 1);
  localparam logic [63:0] SLOT_MASK = (64'd1 << SLOT_BITS) - 64'd1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_GEN  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [GEN_BITS-1:0] gen_mem [0:SLOTS];
  logic [GEN_BITS-1:0] gen_rd_r;
  logic [GEN_BITS-1:0] gen_inc;
  logic [SW-1:0]       gen_cnt_r, gen_cnt_nxt;
  logic                gen_init_r, gen_init_nxt;
  logic [SW-1:0]       slot_r;

  stk_ctrl_t           stk_ctrl;
  stk_stat_t           stk_stat;
  logic [SW-1:0]       pop_slot;
  logic [SW-1:0]       push_slot;

  logic                acc;
  logic [SLOT_BITS-1:0] in_slot;
  logic                in_bad;
  logic [63:0]         handle_wide;

  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         out_handle_r, out_handle_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic                out_load;

  ghp_stack #(.SLOTS(SLOTS)) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (stk_ctrl),
    .push_slot (push_slot),
    .pop_slot  (pop_slot),
    .stat      (stk_stat)
  );

  assign in_stall = !(state_r == S_IDLE && stk_stat.ready && !gen_init_r &&
                      (!out_valid_r || !out_stall));
  assign acc      = in_valid && !in_stall;

  assign in_slot   = in_handle[SLOT_BITS-1:0];
  assign in_bad    = (in_slot == '0) || (32'(in_slot) > 32'(SLOTS));
  assign push_slot = SW'(in_slot);

  assign gen_inc     = gen_rd_r + GEN_BITS'(1);
  assign handle_wide = (64'(gen_inc) << SLOT_BITS) | (64'(slot_r) & SLOT_MASK);

  always_comb begin
    state_nxt      = state_r;
    stk_ctrl       = '0;
    out_load       = 1'b0;
    out_handle_nxt = '0;
    out_status_nxt = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_kind == KIND_ALLOC) begin
            if (stk_stat.empty) begin
              out_load       = 1'b1;
              out_status_nxt = ST_EXHAUSTED;
            end else begin
              stk_ctrl.pop = 1'b1;
              state_nxt    = S_POP;
            end
          end else begin
            out_load = 1'b1;
            if (in_bad) begin
              out_status_nxt = ST_BAD_SLOT;
            end else if (stk_stat.full) begin
              out_status_nxt = ST_FULL;
            end else begin
              stk_ctrl.push = 1'b1;
            end
          end
        end
      end
      S_POP: begin
        state_nxt = S_GEN;
      end
      S_GEN: begin
        out_load       = 1'b1;
        out_handle_nxt = handle_wide[31:0];
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    gen_init_nxt = gen_init_r;
    gen_cnt_nxt  = gen_cnt_r;
    if (gen_init_r) begin
      gen_cnt_nxt = gen_cnt_r + SW'(1);
      if (gen_cnt_r == SW'(SLOTS)) begin
        gen_init_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (gen_init_r) begin
      gen_mem[gen_cnt_r] <= '0;
    end else if (state_r == S_GEN) begin
      gen_mem[slot_r] <= gen_inc;
    end
    if (state_r == S_POP) begin
      gen_rd_r <= gen_mem[pop_slot];
      slot_r   <= pop_slot;
    end
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gen_init_r  <= 1'b1;
      gen_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gen_init_r  <= gen_init_nxt;
      gen_cnt_r   <= gen_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_handle_r <= out_handle_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_new_handle = out_handle_r;
  assign out_status     = out_status_r;

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall)
    else $error("request accepted while allocate in flight");

  a_pop_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP |=> state_r == S_GEN)
    else $error("allocate sequence broken");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GEN |-> !out_valid_r)
    else $error("allocate result would overwrite a pending word");

  a_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GEN |-> slot_r != '0 && 32'(slot_r) <= 32'(SLOTS))
    else $error("popped slot out of range");

endmodule

`default_nettype wire
